/* design/fwmp_pkg.sv */
// ----------------------------------------------------------------------------
// fwmp_pkg
// Shared constants and types for the four-way matrix product engine.
// ----------------------------------------------------------------------------
`default_nettype none
package fwmp_pkg;
    localparam int MAX_M = 16;
    localparam int MAX_N = 16;
    localparam int MAX_P = 16;
    localparam int DIM_W = 5;
    localparam int IDX_W = 4;
    localparam int DATA_W = 32;
    localparam int DEPTH = 256;
    localparam int ADDR_W = 8;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_LOAD_D = 3'd2;
    localparam logic [2:0] OP_COMPUTE = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic [1:0] SEL_AD = 2'd0;
    localparam logic [1:0] SEL_ABT = 2'd1;
    localparam logic [1:0] SEL_DOT = 2'd2;
    localparam logic [1:0] SEL_ATB = 2'd3;

    localparam logic [1:0] REG_ROWS_M = 2'd0;
    localparam logic [1:0] REG_INNER_N = 2'd1;
    localparam logic [1:0] REG_COLS_P = 2'd2;

    typedef logic [DIM_W-1:0] dim_t;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
        if (v == '0)
            return dim_t'(1);
        if (v > maxv)
            return maxv;
        return v;
    endfunction
endpackage
`default_nettype wire

/* design/four_way_matrix_product_engine_top.sv */
// ----------------------------------------------------------------------------
// four_way_matrix_product_engine_top
// Loads A, B and D element by element and forms A*D, A*B', A.*B and A'*B.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    op, row_index, col_index,
//                                             elem_value, result_select
// out       result     out_valid / out_ready  result_value, result_row,
//                                             result_col, result_which
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Load requests write the operand store as they are accepted. A read
// request goes through the registered memory read and then the result
// register; it waits for the output register to be free. A compute
// request first clears all four result stores, one entry of every store
// per cycle, and then walks every output element: each element takes one
// memory read per inner step, then drains the multiply and accumulate
// stages and writes the sum back, through a single multiply-accumulate
// unit. After reset the result stores are cleared by the same pass,
// during which no request is accepted. The operand stores are not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module four_way_matrix_product_engine_top
    import fwmp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        op,
    input  wire logic [3:0]        row_index,
    input  wire logic [3:0]        col_index,
    input  wire logic signed [31:0] elem_value,
    input  wire logic [1:0]        result_select,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     result_value,
    output logic [3:0]             result_row,
    output logic [3:0]             result_col,
    output logic [1:0]             result_which,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [4:0]        cfg_data
);
    // Controller states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    logic [2:0]  state_reg, state_next;
    dim_t        rows_m_reg, inner_n_reg, cols_p_reg;
    logic [ADDR_W-1:0] clr_reg;
    // Compute walk: phase selects which product, i/j the output, k the step.
    logic [1:0]  phase_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic        prod_v_reg;
    logic [DATA_W-1:0] acc_reg, prod_reg;
    logic [1:0]  rd_sel_reg;
    logic        rd_oob_reg;
    logic [3:0]  rd_row_reg, rd_col_reg;

    logic [DATA_W-1:0] a_q, b_q, d_q, ad_q, abt_q, dot_q, atb_q;
    logic [ADDR_W-1:0] a_ra, b_ra, d_ra, res_ra, wa;
    logic [DATA_W-1:0] wd;
    logic        we_a, we_b, we_d, we_ad, we_abt, we_dot, we_atb;

    wire in_fire = in_valid && in_ready;

    assign cfg_ready = 1'b1;
    assign in_ready = (state_reg == ST_IDLE) && !(op == OP_READ && out_valid);

    // Current inner-loop limit and output extents for each phase.
    dim_t k_lim, i_lim, j_lim;
    always_comb
    begin
        case (phase_reg)
            SEL_AD:  begin k_lim = inner_n_reg; i_lim = rows_m_reg;  j_lim = cols_p_reg;  end
            SEL_ABT: begin k_lim = inner_n_reg; i_lim = rows_m_reg;  j_lim = rows_m_reg;  end
            SEL_DOT: begin k_lim = dim_t'(1);   i_lim = rows_m_reg;  j_lim = inner_n_reg; end
            default: begin k_lim = rows_m_reg;  i_lim = inner_n_reg; j_lim = inner_n_reg; end
        endcase
    end

    // Operand read addresses for the step in the compute walk.
    always_comb
    begin
        a_ra = {i_reg, k_reg};
        b_ra = {j_reg, k_reg};
        d_ra = {k_reg, j_reg};
        res_ra = {row_index, col_index};
        case (phase_reg)
            SEL_DOT: begin a_ra = {i_reg, j_reg}; b_ra = {i_reg, j_reg}; end
            SEL_ATB: begin a_ra = {k_reg, i_reg}; b_ra = {k_reg, j_reg}; end
            default: ;
        endcase
    end

    // Write port selection: loads, clearing pass, and compute writeback.
    always_comb
    begin
        we_a = 1'b0; we_b = 1'b0; we_d = 1'b0;
        we_ad = 1'b0; we_abt = 1'b0; we_dot = 1'b0; we_atb = 1'b0;
        wa = {row_index, col_index};
        wd = elem_value;
        if (state_reg == ST_IDLE && in_fire)
        begin
            case (op)
                OP_LOAD_A: we_a = 1'b1;
                OP_LOAD_B: we_b = 1'b1;
                OP_LOAD_D: we_d = 1'b1;
                default: ;
            endcase
        end
        else if (state_reg == ST_CLEAR)
        begin
            wa = clr_reg;
            wd = '0;
            we_ad = 1'b1; we_abt = 1'b1; we_dot = 1'b1; we_atb = 1'b1;
        end
        else if (state_reg == ST_WB)
        begin
            wa = {i_reg, j_reg};
            wd = acc_reg;
            case (phase_reg)
                SEL_AD:  we_ad = 1'b1;
                SEL_ABT: we_abt = 1'b1;
                SEL_DOT: we_dot = 1'b1;
                default: we_atb = 1'b1;
            endcase
        end
    end

    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a (.clk, .we(we_a), .waddr(wa), .wdata(wd), .raddr(a_ra), .rdata(a_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b (.clk, .we(we_b), .waddr(wa), .wdata(wd), .raddr(b_ra), .rdata(b_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_d (.clk, .we(we_d), .waddr(wa), .wdata(wd), .raddr(d_ra), .rdata(d_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ad (.clk, .we(we_ad), .waddr(wa), .wdata(wd), .raddr(res_ra), .rdata(ad_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_abt (.clk, .we(we_abt), .waddr(wa), .wdata(wd), .raddr(res_ra), .rdata(abt_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_dot (.clk, .we(we_dot), .waddr(wa), .wdata(wd), .raddr(res_ra), .rdata(dot_q));
    fwmp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_atb (.clk, .we(we_atb), .waddr(wa), .wdata(wd), .raddr(res_ra), .rdata(atb_q));

    // The second operand depends on the product being formed.
    wire [DATA_W-1:0] op2 = (phase_reg == SEL_AD) ? d_q : b_q;
    wire last_k = ({1'b0, k_reg} + 5'd1) == k_lim;
    wire last_j = ({1'b0, j_reg} + 5'd1) == j_lim;
    wire last_i = ({1'b0, i_reg} + 5'd1) == i_lim;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == ADDR_W'(DEPTH - 1)) state_next = (phase_reg == SEL_ATB) ? ST_IDLE : ST_MAC;
            ST_IDLE:
                if (in_fire && op == OP_READ) state_next = ST_READ;
                else if (in_fire && op == OP_COMPUTE) state_next = ST_CLEAR;
            ST_READ:  state_next = ST_IDLE;
            ST_MAC:   if (last_k) state_next = ST_DRAIN;
            ST_DRAIN: if (!prod_v_reg) state_next = ST_WB;
            ST_WB:
                if (last_j && last_i && phase_reg == SEL_ATB) state_next = ST_IDLE;
                else state_next = ST_MAC;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            phase_reg <= SEL_ATB;  // marks the power-up pass, which returns to idle
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
            prod_v_reg <= 1'b0;
            out_valid <= 1'b0;
            rows_m_reg <= dim_t'(MAX_M);
            inner_n_reg <= dim_t'(MAX_N);
            cols_p_reg <= dim_t'(MAX_P);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_M:  rows_m_reg <= clamp_dim(cfg_data, dim_t'(MAX_M));
                    REG_INNER_N: inner_n_reg <= clamp_dim(cfg_data, dim_t'(MAX_N));
                    REG_COLS_P:  cols_p_reg <= clamp_dim(cfg_data, dim_t'(MAX_P));
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (state_reg == ST_READ)
                out_valid <= 1'b1;
            // Product stage: one operand read in flight per MAC cycle.
            prod_v_reg <= (state_reg == ST_MAC);
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        phase_reg <= SEL_AD;
                        i_reg <= '0; j_reg <= '0; k_reg <= '0;
                    end
                end
                ST_IDLE: if (in_fire && op == OP_COMPUTE) phase_reg <= SEL_AD;
                ST_MAC:
                begin
                    if (!last_k) k_reg <= k_reg + 1'b1;
                end
                ST_WB:
                begin
                    k_reg <= '0;
                    if (!last_j) j_reg <= j_reg + 1'b1;
                    else
                    begin
                        j_reg <= '0;
                        if (!last_i) i_reg <= i_reg + 1'b1;
                        else
                        begin
                            i_reg <= '0;
                            phase_reg <= phase_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath: memory data arrives the cycle after the read, is multiplied
    // into prod_reg, and accumulated the cycle after that.
    logic mul_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else
            mul_v_reg <= prod_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (prod_v_reg)
            prod_reg <= a_q * op2;
        if (state_reg == ST_WB || state_reg == ST_CLEAR)
            acc_reg <= '0;
        else if (mul_v_reg)
            acc_reg <= acc_reg + prod_reg;
        if (state_reg == ST_IDLE && in_fire)
        begin
            rd_sel_reg <= result_select;
            rd_row_reg <= row_index;
            rd_col_reg <= col_index;
            rd_oob_reg <= 1'b0;
        end
        if (state_reg == ST_READ)
        begin
            result_row <= rd_row_reg;
            result_col <= rd_col_reg;
            result_which <= rd_sel_reg;
            case (rd_sel_reg)
                SEL_AD:  result_value <= rd_oob_reg ? '0 : ad_q;
                SEL_ABT: result_value <= abt_q;
                SEL_DOT: result_value <= dot_q;
                default: result_value <= atb_q;
            endcase
        end
    end

    // A result is only raised by a read, and the output register is never
    // overwritten while it still holds an unaccepted result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result dropped while stalled");
    a_read_gated: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == OP_READ |-> !out_valid)
        else $error("read accepted over a pending result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("request accepted while busy");
endmodule
`default_nettype wire

/* design/fwmp_ram.sv */
// ----------------------------------------------------------------------------
// fwmp_ram
// Generic single-port-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module fwmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* test/four_way_matrix_product_engine_top_tb.sv */
// ----------------------------------------------------------------------------
// four_way_matrix_product_engine_top_tb
// Self-checking bench for the four-way matrix product engine. A scoreboard
// class keeps its own copy of the operand and product matrices, forms the
// four products on every compute request and queues the value each read
// request must return. Requests are driven with random gaps and the result
// channel stalls at random, save in gap-free phases. The bench runs a short
// directed part and then random phases under several dimension settings.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [31:0] value;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [1:0]  which;
} read_result_t;

class fwmp_scoreboard;
    logic [31:0] a_m[16][16];
    logic [31:0] b_m[16][16];
    logic [31:0] d_m[16][16];
    logic [31:0] ad_m[16][16];
    logic [31:0] abt_m[16][16];
    logic [31:0] dot_m[16][16];
    logic [31:0] atb_m[16][16];
    int unsigned m_dim;
    int unsigned n_dim;
    int unsigned p_dim;
    read_result_t pending_reads[$];

    function new();
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
            begin
                a_m[i][j] = '0; b_m[i][j] = '0; d_m[i][j] = '0;
                ad_m[i][j] = '0; abt_m[i][j] = '0;
                dot_m[i][j] = '0; atb_m[i][j] = '0;
            end
        m_dim = 16;
        n_dim = 16;
        p_dim = 16;
    endfunction

    static function int unsigned clamp(logic [4:0] v);
        if (v == 5'd0)
            return 1;
        if (v > 5'd16)
            return 16;
        return v;
    endfunction

    function void configure(logic [1:0] idx, logic [4:0] data);
        if (idx == fwmp_pkg::REG_ROWS_M)
            m_dim = clamp(data);
        else if (idx == fwmp_pkg::REG_INNER_N)
            n_dim = clamp(data);
        else if (idx == fwmp_pkg::REG_COLS_P)
            p_dim = clamp(data);
    endfunction

    function void form_products();
        logic [31:0] acc;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
            begin
                ad_m[i][j] = '0; abt_m[i][j] = '0;
                dot_m[i][j] = '0; atb_m[i][j] = '0;
            end
        for (int i = 0; i < m_dim; i++)
        begin
            for (int j = 0; j < p_dim; j++)
            begin
                acc = '0;
                for (int k = 0; k < n_dim; k++)
                    acc = acc + a_m[i][k] * d_m[k][j];
                ad_m[i][j] = acc;
            end
            // The transposed product spans all m columns.
            for (int j = 0; j < m_dim; j++)
            begin
                acc = '0;
                for (int k = 0; k < n_dim; k++)
                    acc = acc + a_m[i][k] * b_m[j][k];
                abt_m[i][j] = acc;
            end
            for (int j = 0; j < n_dim; j++)
                dot_m[i][j] = a_m[i][j] * b_m[i][j];
        end
        for (int i = 0; i < n_dim; i++)
            for (int j = 0; j < n_dim; j++)
            begin
                acc = '0;
                for (int k = 0; k < m_dim; k++)
                    acc = acc + a_m[k][i] * b_m[k][j];
                atb_m[i][j] = acc;
            end
    endfunction

    function void note_request(logic [2:0] op, logic [3:0] r, logic [3:0] c,
                               logic [31:0] v, logic [1:0] sel);
        read_result_t res;
        case (op)
            fwmp_pkg::OP_LOAD_A: a_m[r][c] = v;
            fwmp_pkg::OP_LOAD_B: b_m[r][c] = v;
            fwmp_pkg::OP_LOAD_D: d_m[r][c] = v;
            fwmp_pkg::OP_COMPUTE: form_products();
            fwmp_pkg::OP_READ:
            begin
                case (sel)
                    fwmp_pkg::SEL_AD: res.value = ad_m[r][c];
                    fwmp_pkg::SEL_ABT: res.value = abt_m[r][c];
                    fwmp_pkg::SEL_DOT: res.value = dot_m[r][c];
                    default: res.value = atb_m[r][c];
                endcase
                res.row = r;
                res.col = c;
                res.which = sel;
                pending_reads.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Returns an empty string when the result matches the oldest read.
    function string check_result(logic [31:0] v, logic [3:0] r, logic [3:0] c,
                                 logic [1:0] w);
        read_result_t e;
        string msg;
        if (pending_reads.size() == 0)
            return $sformatf("result with no pending read (row %0d col %0d)", r, c);
        e = pending_reads.pop_front();
        msg = "";
        if (v !== e.value)
            msg = {msg, $sformatf(" value %h/%h", v, e.value)};
        if (r !== e.row)
            msg = {msg, $sformatf(" row %0d/%0d", r, e.row)};
        if (c !== e.col)
            msg = {msg, $sformatf(" col %0d/%0d", c, e.col)};
        if (w !== e.which)
            msg = {msg, $sformatf(" which %0d/%0d", w, e.which)};
        if (msg != "")
            msg = {$sformatf("read %0d,%0d sel %0d got/want:", e.row, e.col, e.which),
                   msg};
        return msg;
    endfunction

    function int outstanding();
        return pending_reads.size();
    endfunction
endclass

module four_way_matrix_product_engine_top_tb;
    import fwmp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         op;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] elem_value;
    logic [1:0]         result_select;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result_value;
    logic [3:0]         result_row;
    logic [3:0]         result_col;
    logic [1:0]         result_which;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [4:0]         cfg_data;

    fwmp_scoreboard products;
    int                 error_count;
    int                 quiet_cycles;
    // When set, neither side inserts gaps, so requests go back to back.
    bit                 no_gaps;
    // Which operand entries the bench has loaded since reset. A compute
    // request is only issued once every entry it will use has been loaded.
    bit                 a_loaded[16][16];
    bit                 b_loaded[16][16];
    bit                 d_loaded[16][16];
    int unsigned        use_m;
    int unsigned        use_n;
    int unsigned        use_p;

    four_way_matrix_product_engine_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .row_index(row_index), .col_index(col_index),
        .elem_value(elem_value), .result_select(result_select),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .result_row(result_row),
        .result_col(result_col), .result_which(result_which),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // The watchdog counts cycles in which no handshake completes on any
    // channel. The limit sits well above the time a full-size compute keeps
    // the block busy.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("four_way_matrix_product_engine_top_tb: errors");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each result, then
    // take it and compare it against the oldest pending read.
    initial
    begin
        int stall;
        string msg;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(15, 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            msg = products.check_result(result_value, result_row, result_col,
                                        result_which);
            if (msg != "")
                report(msg);
        end
    end

    // Drives one request and returns once it has been accepted. The valid is
    // left high so that a back-to-back request does not drop it.
    task automatic send_request(logic [2:0] o, logic [3:0] r, logic [3:0] c,
                                logic [31:0] v, logic [1:0] sel);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(15, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        row_index <= r;
        col_index <= c;
        elem_value <= v;
        result_select <= sel;
        do
            @(posedge clk);
        while (!in_ready);
        products.note_request(o, r, c, v, sel);
        case (o)
            OP_LOAD_A: a_loaded[r][c] = 1'b1;
            OP_LOAD_B: b_loaded[r][c] = 1'b1;
            OP_LOAD_D: d_loaded[r][c] = 1'b1;
            default: ;
        endcase
    endtask

    // Loads every operand entry the next compute will touch that has not
    // been loaded yet.
    task automatic fill_operands();
        for (int i = 0; i < use_m; i++)
            for (int k = 0; k < use_n; k++)
            begin
                if (!a_loaded[i][k])
                    send_request(OP_LOAD_A, 4'(i), 4'(k), $urandom, SEL_AD);
                if (!b_loaded[i][k])
                    send_request(OP_LOAD_B, 4'(i), 4'(k), $urandom, SEL_AD);
            end
        for (int k = 0; k < use_n; k++)
            for (int j = 0; j < use_p; j++)
                if (!d_loaded[k][j])
                    send_request(OP_LOAD_D, 4'(k), 4'(j), $urandom, SEL_AD);
    endtask

    task automatic compute_request();
        fill_operands();
        send_request(OP_COMPUTE, 4'($urandom), 4'($urandom), $urandom, 2'($urandom));
    endtask

    // A read issued behind any compute comes back only after that compute
    // is done, so once it has returned the block is idle.
    task automatic wait_idle();
        send_request(OP_READ, 4'd0, 4'd0, 32'd0, SEL_AD);
        in_valid <= 1'b0;
        @(posedge clk);
        while (products.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [4:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        products.configure(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dims(logic [4:0] m, logic [4:0] n, logic [4:0] p);
        write_register(REG_ROWS_M, m);
        write_register(REG_INNER_N, n);
        write_register(REG_COLS_P, p);
        use_m = products.clamp(m);
        use_n = products.clamp(n);
        use_p = products.clamp(p);
    endtask

    // Draws a dimension setting; now and then the value is out of range and
    // the block must clamp it.
    function automatic logic [4:0] pick_dim(bit keep_small);
        int roll;
        roll = $urandom_range(9, 0);
        if (roll == 0)
            return 5'd0;
        if (roll == 1)
            return 5'($urandom_range(31, 17));
        if (keep_small)
            return 5'($urandom_range(5, 1));
        return 5'($urandom_range(16, 1));
    endfunction

    task automatic random_request();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 55)
            send_request(3'($urandom_range(OP_LOAD_D, OP_LOAD_A)), 4'($urandom),
                         4'($urandom), $urandom, 2'($urandom));
        else if (roll < 91)
            send_request(OP_READ, 4'($urandom), 4'($urandom), $urandom, 2'($urandom));
        else if (roll < 96)
            compute_request();
        else
            // Codes above the read are undefined and must be ignored.
            send_request(3'($urandom_range(7, OP_READ + 1)), 4'($urandom),
                         4'($urandom), $urandom, 2'($urandom));
    endtask

    initial
    begin
        logic [31:0] extremes[4];
        products = new();
        error_count = 0;
        no_gaps = 1'b0;
        use_m = 16;
        use_n = 16;
        use_p = 16;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
            begin
                a_loaded[i][j] = 1'b0;
                b_loaded[i][j] = 1'b0;
                d_loaded[i][j] = 1'b0;
            end
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_LOAD_A;
        row_index <= '0;
        col_index <= '0;
        elem_value <= '0;
        result_select <= SEL_AD;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ROWS_M;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a 2x2 setting, operands at the extremes of the
        // signed range, reads before and after compute, every read target,
        // reads outside the region in use, and undefined op codes.
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001};
        set_dims(5'd2, 5'd2, 5'd2);
        send_request(OP_READ, 4'd15, 4'd15, 32'hffff_ffff, SEL_ATB);
        for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++)
            begin
                send_request(OP_LOAD_A, 4'(i), 4'(k), extremes[2*i+k], SEL_AD);
                send_request(OP_LOAD_B, 4'(i), 4'(k), extremes[3-(2*i+k)], SEL_AD);
                send_request(OP_LOAD_D, 4'(i), 4'(k), extremes[(2*i+k+1)%4], SEL_AD);
            end
        compute_request();
        send_request(OP_READ, 4'd1, 4'd1, 32'd0, SEL_AD);
        send_request(OP_READ, 4'd0, 4'd1, 32'd0, SEL_ABT);
        send_request(OP_READ, 4'd1, 4'd0, 32'd0, SEL_DOT);
        send_request(OP_READ, 4'd1, 4'd1, 32'd0, SEL_ATB);
        send_request(OP_READ, 4'd15, 4'd0, 32'd0, SEL_DOT);
        send_request(3'd5, 4'd0, 4'd0, 32'h1234_5678, SEL_AD);
        send_request(3'd7, 4'd15, 4'd15, 32'hffff_ffff, SEL_ATB);
        send_request(OP_READ, 4'd0, 4'd0, 32'd0, SEL_AD);
        wait_idle();

        // Random phases. The first few pin the extremes of the dimensions;
        // later ones keep m, n and, in the last, p mostly small to save time.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_dims(5'd1, 5'd1, 5'd1);
                1: set_dims(5'd31, 5'd1, 5'd17);
                2: set_dims(5'd0, 5'd31, 5'd1);
                3: set_dims(5'd2, 5'd16, 5'd2);
                default: set_dims(pick_dim(1'b1), pick_dim(1'b1), pick_dim(phase == 7));
            endcase
            no_gaps = (phase % 3 == 1);
            compute_request();
            for (int n = 0; n < 20; n++)
                random_request();
            compute_request();
            for (int n = 0; n < 6; n++)
                send_request(OP_READ, 4'($urandom_range(use_m - 1, 0)),
                             4'($urandom_range(use_n - 1, 0)), $urandom,
                             2'($urandom));
            no_gaps = 1'b0;
            wait_idle();
        end

        if (products.outstanding() != 0)
            report("read left without a result");
        if (error_count == 0)
            $display("four_way_matrix_product_engine_top_tb: clean");
        else
            $display("four_way_matrix_product_engine_top_tb: errors");
        $finish;
    end
endmodule

`default_nettype wire

/* filelist.f */
design/fwmp_pkg.sv
design/fwmp_ram.sv
design/four_way_matrix_product_engine_top.sv
test/four_way_matrix_product_engine_top_tb.sv
